[sv/sfcc_pkg.sv]
// Shared types and constants of the sphere frustum clip and cull block.
`default_nettype none
package sfcc_pkg;

    localparam int FLAG_W     = 6;
    localparam int FLAG_IDX_W = 3;
    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int LIM_W      = COORD_W + 2;
    localparam int FRAC_W     = 16;
    localparam int SEL_W      = 2;
    localparam int STEP_W     = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CULL = 1'b1;

    localparam logic [SEL_W-1:0] SEL_X = 2'd0;
    localparam logic [SEL_W-1:0] SEL_Y = 2'd1;
    localparam logic [SEL_W-1:0] SEL_Z = 2'd2;

    typedef struct packed {
        logic             capture;
        logic             load;
        logic             mul;
        logic [SEL_W-1:0] sel;
        logic             acc;
        logic             acc_first;
        logic             check;
    } t_dp_cmd;

    typedef struct packed {
        logic test_bit;
        logic hit;
    } t_dp_stat;

endpackage
`default_nettype wire

[sv/sfcc_datapath.sv]
// Datapath: plane store, shared multiplier, dot product accumulator and limit compare.
`default_nettype none
module sfcc_datapath #(
    parameter int NUM_PLANES = 6
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire sfcc_pkg::t_dp_cmd                i_cmd,
    input  wire [$clog2(((NUM_PLANES < sfcc_pkg::FLAG_W) ? NUM_PLANES : sfcc_pkg::FLAG_W) + 1)-1:0]
                                                  i_plane,
    input  wire [2:0]                             i_plane_index,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_normal_x,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_normal_y,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_normal_z,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_plane_d,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_center_x,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_center_y,
    input  wire signed [sfcc_pkg::COORD_W-1:0]    i_center_z,
    input  wire [sfcc_pkg::RAD_W-1:0]             i_radius,
    input  wire [sfcc_pkg::FLAG_W-1:0]            i_clip_flags,
    input  wire [sfcc_pkg::FLAG_W-1:0]            i_clip_mask,
    output sfcc_pkg::t_dp_stat                    o_stat,
    output logic                                  o_culled,
    output logic [sfcc_pkg::FLAG_W-1:0]           o_flags_out
);

    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    logic signed [sfcc_pkg::COORD_W-1:0] r_nx  [NUM_PLANES];
    logic signed [sfcc_pkg::COORD_W-1:0] r_ny  [NUM_PLANES];
    logic signed [sfcc_pkg::COORD_W-1:0] r_nz  [NUM_PLANES];
    logic signed [sfcc_pkg::COORD_W-1:0] r_off [NUM_PLANES];

    logic signed [sfcc_pkg::COORD_W-1:0] r_cx;
    logic signed [sfcc_pkg::COORD_W-1:0] r_cy;
    logic signed [sfcc_pkg::COORD_W-1:0] r_cz;
    logic [sfcc_pkg::RAD_W-1:0]          r_radius;
    logic [sfcc_pkg::FLAG_W-1:0]         r_test;
    logic [sfcc_pkg::FLAG_W-1:0]         r_flags;
    logic                                r_culled;

    logic signed [sfcc_pkg::PROD_W-1:0]  r_prod;
    logic signed [sfcc_pkg::ACC_W-1:0]   r_acc;
    logic signed [sfcc_pkg::ACC_W-1:0]   r_hi_lim;
    logic signed [sfcc_pkg::ACC_W-1:0]   r_lo_lim;

    logic [PIDX_W-1:0]                   w_rd;
    logic [sfcc_pkg::FLAG_IDX_W-1:0]     w_bit;
    logic signed [sfcc_pkg::COORD_W-1:0] w_a;
    logic signed [sfcc_pkg::COORD_W-1:0] w_b;
    logic signed [sfcc_pkg::PROD_W-1:0]  w_prod;
    logic signed [sfcc_pkg::COORD_W-1:0] w_d;
    logic signed [sfcc_pkg::LIM_W-1:0]   w_rad;
    logic signed [sfcc_pkg::LIM_W-1:0]   w_sum_hi;
    logic signed [sfcc_pkg::LIM_W-1:0]   w_sum_lo;
    logic                                w_load_ok;
    logic                                w_below;

    assign w_rd  = PIDX_W'(i_plane);
    assign w_bit = sfcc_pkg::FLAG_IDX_W'(i_plane);
    assign w_d   = r_off[w_rd];

    always_comb begin
        case (i_cmd.sel)
            sfcc_pkg::SEL_X: begin
                w_a = r_nx[w_rd];
                w_b = r_cx;
            end
            sfcc_pkg::SEL_Y: begin
                w_a = r_ny[w_rd];
                w_b = r_cy;
            end
            default: begin
                w_a = r_nz[w_rd];
                w_b = r_cz;
            end
        endcase
    end

    assign w_prod   = w_a * w_b;
    assign w_rad    = $signed({{(sfcc_pkg::LIM_W - sfcc_pkg::RAD_W){1'b0}}, r_radius});
    assign w_sum_hi = sfcc_pkg::LIM_W'(w_d) + w_rad;
    assign w_sum_lo = sfcc_pkg::LIM_W'(w_d) - w_rad;

    // (d + r) * 2^16 < dot means the sphere lies wholly outside this plane
    assign o_stat.hit      = r_hi_lim < r_acc;
    assign o_stat.test_bit = r_test[w_bit];
    assign w_below         = r_acc < r_lo_lim;
    assign w_load_ok       = 32'(i_plane_index) < NUM_PLANES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_nx[i]  <= '0;
                r_ny[i]  <= '0;
                r_nz[i]  <= '0;
                r_off[i] <= '0;
            end
        end else if (i_cmd.load && w_load_ok) begin
            r_nx[PIDX_W'(i_plane_index)]  <= i_normal_x;
            r_ny[PIDX_W'(i_plane_index)]  <= i_normal_y;
            r_nz[PIDX_W'(i_plane_index)]  <= i_normal_z;
            r_off[PIDX_W'(i_plane_index)] <= i_plane_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_cz     <= i_center_z;
            r_radius <= i_radius;
            r_test   <= i_clip_flags & i_clip_mask;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul && i_cmd.sel == sfcc_pkg::SEL_X) begin
            r_hi_lim <= sfcc_pkg::ACC_W'($signed({w_sum_hi, {sfcc_pkg::FRAC_W{1'b0}}}));
            r_lo_lim <= sfcc_pkg::ACC_W'($signed({w_sum_lo, {sfcc_pkg::FRAC_W{1'b0}}}));
        end
        if (i_cmd.acc) begin
            if (i_cmd.acc_first) begin
                r_acc <= sfcc_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + sfcc_pkg::ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_culled <= 1'b0;
            r_flags  <= '0;
        end else if (i_cmd.capture) begin
            r_culled <= 1'b0;
            r_flags  <= i_clip_flags;
        end else if (i_cmd.check) begin
            if (o_stat.hit) begin
                r_culled <= 1'b1;
                r_flags  <= '0;
            end else if (w_below) begin
                r_flags[w_bit] <= 1'b0;
            end
        end
    end

    assign o_culled    = r_culled;
    assign o_flags_out = r_flags;

endmodule
`default_nettype wire

[sv/sfcc_ctrl.sv]
// Controller: walks the planes of one cull transfer and sequences the shared multiplier.
`default_nettype none
module sfcc_ctrl #(
    parameter int NUM_PLANES = 6
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire                 i_opcode,
    input  wire sfcc_pkg::t_dp_stat i_stat,
    output sfcc_pkg::t_dp_cmd   o_cmd,
    output logic [$clog2(((NUM_PLANES < sfcc_pkg::FLAG_W) ? NUM_PLANES : sfcc_pkg::FLAG_W) + 1)-1:0]
                                o_plane,
    output logic                busy,
    output logic                o_valid
);

    localparam int NTEST = (NUM_PLANES < sfcc_pkg::FLAG_W) ? NUM_PLANES : sfcc_pkg::FLAG_W;
    localparam int CNT_W = $clog2(NTEST + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DOT   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [sfcc_pkg::STEP_W-1:0] STEP_LAST = 2'd3;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [CNT_W-1:0]            r_plane;
    logic [CNT_W-1:0]            n_plane;
    logic [sfcc_pkg::STEP_W-1:0] r_step;
    logic [sfcc_pkg::STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_opcode == sfcc_pkg::OP_CULL) begin
                        o_cmd.capture = 1'b1;
                        n_plane       = '0;
                        n_state       = ST_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_plane == CNT_W'(NTEST)) begin
                    n_state = ST_DONE;
                end else if (i_stat.test_bit) begin
                    n_step  = '0;
                    n_state = ST_DOT;
                end else begin
                    n_plane = r_plane + 1'b1;
                end
            end
            ST_DOT: begin
                // product of step k is accumulated in step k + 1
                o_cmd.mul       = r_step != STEP_LAST;
                o_cmd.sel       = r_step;
                o_cmd.acc       = r_step != '0;
                o_cmd.acc_first = r_step == 2'd1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.hit) begin
                    n_state = ST_DONE;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_plane <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_plane <= n_plane;
            r_step  <= n_step;
        end
    end

    assign o_plane = r_plane;
    assign busy    = r_state != ST_IDLE;
    assign o_valid = r_state == ST_DONE;

endmodule
`default_nettype wire

[sv/sphere_frustum_clip_cull.sv]
// Top level of the sphere frustum clip and cull block.
//
// Command port: a transfer is taken at a rising edge with start high and busy low.
// i_opcode selects a plane load or a sphere test. A load writes plane
// i_plane_index (ignored when the index is NUM_PLANES or above) in the cycle it
// is taken, gives no result and leaves busy low.
// A sphere test raises busy. The controller walks the first min(NUM_PLANES, 6)
// planes in ascending order, and each plane set in both i_clip_flags and
// i_clip_mask takes three products on the one shared 32x32 multiplier with
// their accumulation, then the limit compare. The test stops at the first plane
// that culls the sphere. The next transfer is taken the cycle after the strobe.
// Result: o_valid is high for exactly one cycle with o_culled and o_flags_out;
// the receiver cannot hold it off.
// Reset clears all planes to zero and returns the controller to idle.
`default_nettype none
module sphere_frustum_clip_cull #(
    parameter int NUM_PLANES = 6
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_opcode,
    input  wire [2:0]                          i_plane_index,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_normal_x,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_normal_y,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_normal_z,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_plane_d,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_center_x,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_center_y,
    input  wire signed [sfcc_pkg::COORD_W-1:0] i_center_z,
    input  wire [sfcc_pkg::RAD_W-1:0]          i_radius,
    input  wire [sfcc_pkg::FLAG_W-1:0]         i_clip_flags,
    input  wire [sfcc_pkg::FLAG_W-1:0]         i_clip_mask,
    output logic                               o_valid,
    output logic                               o_culled,
    output logic [sfcc_pkg::FLAG_W-1:0]        o_flags_out
);

    localparam int NTEST = (NUM_PLANES < sfcc_pkg::FLAG_W) ? NUM_PLANES : sfcc_pkg::FLAG_W;
    localparam int CNT_W = $clog2(NTEST + 1);

    sfcc_pkg::t_dp_cmd  w_cmd;
    sfcc_pkg::t_dp_stat w_stat;
    logic [CNT_W-1:0]   w_plane;

    sfcc_ctrl #(
        .NUM_PLANES (NUM_PLANES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_plane  (w_plane),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    sfcc_datapath #(
        .NUM_PLANES (NUM_PLANES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_plane       (w_plane),
        .i_plane_index (i_plane_index),
        .i_normal_x    (i_normal_x),
        .i_normal_y    (i_normal_y),
        .i_normal_z    (i_normal_z),
        .i_plane_d     (i_plane_d),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_center_z    (i_center_z),
        .i_radius      (i_radius),
        .i_clip_flags  (i_clip_flags),
        .i_clip_mask   (i_clip_mask),
        .o_stat        (w_stat),
        .o_culled      (o_culled),
        .o_flags_out   (o_flags_out)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_culled_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_culled) |-> (o_flags_out == '0))
        else $error("culled result with flags set");

    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy == ($past(i_opcode) == sfcc_pkg::OP_CULL)))
        else $error("busy does not follow the command taken");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a sphere test");

endmodule
`default_nettype wire
